@@ rtl/pbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and character codes for the pileup base counter.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int INDEL_LEN_WIDTH = 10;
    localparam int NUM_BINS        = 5;

    localparam logic [7:0] CH_CARET = 8'h5E;  // '^'
    localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LT    = 8'h74;

    localparam logic [2:0] BIN_A = 3'd0;
    localparam logic [2:0] BIN_C = 3'd1;
    localparam logic [2:0] BIN_G = 3'd2;
    localparam logic [2:0] BIN_T = 3'd3;
    localparam logic [2:0] BIN_N = 3'd4;

    typedef struct packed {
        logic [7:0] symbol;
        logic [2:0] ref_base;
        logic       last_symbol;
    } pbc_in_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count_a;
        logic [COUNT_WIDTH-1:0] count_c;
        logic [COUNT_WIDTH-1:0] count_g;
        logic [COUNT_WIDTH-1:0] count_t;
        logic [COUNT_WIDTH-1:0] count_n;
    } pbc_out_t;

endpackage

@@ rtl/pbc_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_in_stage
// Input register holding one request until the core consumes it.
// ----------------------------------------------------------------------------
module pbc_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pbc_pkg::pbc_in_t in_data,
    input  logic             advance,
    output logic             held_valid,
    output pbc_pkg::pbc_in_t held_data
);

    logic             valid_reg;
    pbc_pkg::pbc_in_t data_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

@@ rtl/pbc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_core
// Parse state, indel length and saturating base counters; one symbol a cycle while advance is high.
// ----------------------------------------------------------------------------
module pbc_core
#(
    parameter int INDEL_LEN_WIDTH = pbc_pkg::INDEL_LEN_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  pbc_pkg::pbc_in_t  item,
    output pbc_pkg::pbc_out_t result
);

    localparam int CW = pbc_pkg::COUNT_WIDTH;
    localparam int LW = INDEL_LEN_WIDTH;

    typedef enum logic [1:0]
    {
        MODE_NORMAL = 2'd0,
        MODE_SKIP1  = 2'd1,
        MODE_DIGITS = 2'd2,
        MODE_SKIPN  = 2'd3
    } mode_t;

    mode_t           mode_reg, mode_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [CW-1:0]   count_reg  [pbc_pkg::NUM_BINS];
    logic [CW-1:0]   count_next [pbc_pkg::NUM_BINS];
    logic [CW-1:0]   count_upd  [pbc_pkg::NUM_BINS];

    logic            bump_en;
    logic [2:0]      bump_bin;
    logic [2:0]      sym_bin;
    logic            is_digit;
    logic [LW+3:0]   len_x10;
    logic [LW-1:0]   len_sat;
    logic [LW-1:0]   len_dec;
    logic [7:0]      digit;

    always_comb
    begin
        case (item.symbol)
            pbc_pkg::CH_UA, pbc_pkg::CH_LA: sym_bin = pbc_pkg::BIN_A;
            pbc_pkg::CH_UC, pbc_pkg::CH_LC: sym_bin = pbc_pkg::BIN_C;
            pbc_pkg::CH_UG, pbc_pkg::CH_LG: sym_bin = pbc_pkg::BIN_G;
            pbc_pkg::CH_UT, pbc_pkg::CH_LT: sym_bin = pbc_pkg::BIN_T;
            default:                        sym_bin = pbc_pkg::BIN_N;
        endcase
    end

    assign is_digit = (item.symbol >= pbc_pkg::CH_ZERO) && (item.symbol <= pbc_pkg::CH_NINE);
    assign digit    = item.symbol - pbc_pkg::CH_ZERO;
    assign len_x10  = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0}
                    + {{LW{1'b0}}, digit[3:0]};
    assign len_sat  = (len_x10[LW+3:LW] != 4'd0) ? {LW{1'b1}} : len_x10[LW-1:0];
    assign len_dec  = len_reg - {{(LW-1){1'b0}}, 1'b1};

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        bump_en   = 1'b0;
        bump_bin  = pbc_pkg::BIN_N;
        case (mode_reg)
            MODE_SKIP1:
            begin
                mode_next = MODE_NORMAL;
            end
            MODE_SKIPN:
            begin
                if (len_reg > {LW{1'b0}})
                begin
                    len_next = len_dec;
                end
                if (len_reg <= {{(LW-1){1'b0}}, 1'b1})
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            default:
            begin
                if (mode_reg == MODE_DIGITS && is_digit)
                begin
                    len_next = len_sat;
                end
                else if (mode_reg == MODE_DIGITS && len_reg != {LW{1'b0}})
                begin
                    len_next  = len_dec;
                    mode_next = (len_dec == {LW{1'b0}}) ? MODE_NORMAL : MODE_SKIPN;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    if (item.symbol == pbc_pkg::CH_CARET)
                    begin
                        mode_next = MODE_SKIP1;
                    end
                    else if (item.symbol == pbc_pkg::CH_DOLLAR
                          || item.symbol == pbc_pkg::CH_STAR)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (item.symbol == pbc_pkg::CH_PLUS
                          || item.symbol == pbc_pkg::CH_MINUS)
                    begin
                        mode_next = MODE_DIGITS;
                        len_next  = {LW{1'b0}};
                    end
                    else if (item.symbol == pbc_pkg::CH_COMMA
                          || item.symbol == pbc_pkg::CH_DOT)
                    begin
                        bump_en  = 1'b1;
                        bump_bin = (item.ref_base < pbc_pkg::BIN_N) ? item.ref_base
                                                                    : pbc_pkg::BIN_N;
                    end
                    else
                    begin
                        bump_en  = 1'b1;
                        bump_bin = sym_bin;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < pbc_pkg::NUM_BINS; i++)
        begin
            count_upd[i] = count_reg[i];
            if (bump_en && bump_bin == 3'(i) && count_reg[i] != {CW{1'b1}})
            begin
                count_upd[i] = count_reg[i] + {{(CW-1){1'b0}}, 1'b1};
            end
            count_next[i] = item.last_symbol ? {CW{1'b0}} : count_upd[i];
        end
    end

    assign result.count_a = count_upd[0];
    assign result.count_c = count_upd[1];
    assign result.count_g = count_upd[2];
    assign result.count_t = count_upd[3];
    assign result.count_n = count_upd[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            len_reg  <= {LW{1'b0}};
            for (int i = 0; i < pbc_pkg::NUM_BINS; i++)
            begin
                count_reg[i] <= {CW{1'b0}};
            end
        end
        else if (advance)
        begin
            mode_reg <= item.last_symbol ? MODE_NORMAL : mode_next;
            len_reg  <= item.last_symbol ? {LW{1'b0}} : len_next;
            for (int i = 0; i < pbc_pkg::NUM_BINS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

@@ rtl/pbc_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_out_stage
// Result register; holds the counts until the downstream side takes them.
// ----------------------------------------------------------------------------
module pbc_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pbc_pkg::pbc_out_t load_data,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output pbc_pkg::pbc_out_t out_data
);

    logic              valid_reg;
    pbc_pkg::pbc_out_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            data_reg <= load_data;
        end
    end

endmodule

@@ rtl/pileup_base_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_base_counter
// Path: a last symbol's counts pass from the input register to the result register.
// Throughput: one symbol per cycle, unless a last symbol waits on a full
// result register; state and counters update between the two registers.
// Reset: rst_n clears parse mode, indel length, counts and both valid flags.
// ----------------------------------------------------------------------------
module pileup_base_counter
#(
    parameter int INDEL_LEN_WIDTH = pbc_pkg::INDEL_LEN_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pbc_pkg::pbc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pbc_pkg::pbc_out_t out_data
);

    logic              held_valid;
    pbc_pkg::pbc_in_t  held_data;
    logic              out_free;
    logic              advance;
    pbc_pkg::pbc_out_t result;

    // a last symbol waits only when the result register is still occupied
    assign advance = held_valid && (!held_data.last_symbol || out_free);

    pbc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    pbc_core
    #(
        .INDEL_LEN_WIDTH (INDEL_LEN_WIDTH)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_data),
        .result  (result)
    );

    pbc_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && held_data.last_symbol),
        .load_data (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
